// ----- sv/probe_request_rssi_table_defines.svh -----
// Assertion macros used by the probe request table engine.
`ifndef PROBE_REQUEST_RSSI_TABLE_DEFINES_SVH
`define PROBE_REQUEST_RSSI_TABLE_DEFINES_SVH

`ifndef SYNTH
// Property checked only while out of reset.
`define PRT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every edge, reset included.
`define PRT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRT_ASSERT(label, clk, rst_n, prop, msg)
`define PRT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- sv/prt_pkg.sv -----
package prt_pkg;

	localparam int TABLE_SIZE = 16;
	localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
	localparam int MAC_W      = 48;
	localparam int SIG_W      = 8;
	localparam int SLOT_W     = 4;
	localparam int EVT_W      = 32;

	localparam logic [EVT_W-1:0] COUNT_TOP = 32'h8000_0000;
	localparam logic [EVT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Slot that follows the counter wrap: the top value modulo the table size.
	localparam logic [IDX_W-1:0] WRAP_SLOT = IDX_W'(64'h8000_0000 % 64'(TABLE_SIZE));
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

	typedef struct packed {
		logic [MAC_W-1:0]        mac;
		logic signed [SIG_W-1:0] lo;
		logic signed [SIG_W-1:0] hi;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                    was_hit;
		logic [SLOT_W-1:0]       slot_used;
		logic signed [SIG_W-1:0] lowest_strength;
		logic signed [SIG_W-1:0] highest_strength;
		logic [EVT_W-1:0]        events_seen;
	} result_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

endpackage

// ----- sv/prt_stream_if.sv -----
interface prt_req_if import prt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [MAC_W-1:0]        station_mac;
	logic signed [SIG_W-1:0] signal_strength;

	modport source (output valid, output station_mac, output signal_strength, input ready);
	modport sink (input valid, input station_mac, input signal_strength, output ready);
endinterface

interface prt_res_if import prt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    was_hit;
	logic [SLOT_W-1:0]       slot_used;
	logic signed [SIG_W-1:0] lowest_strength;
	logic signed [SIG_W-1:0] highest_strength;
	logic [EVT_W-1:0]        events_seen;

	modport source (output valid, output was_hit, output slot_used, output lowest_strength,
		output highest_strength, output events_seen, input ready);
	modport sink (input valid, input was_hit, input slot_used, input lowest_strength,
		input highest_strength, input events_seen, output ready);
endinterface

// ----- sv/probe_request_rssi_table.sv -----
// Probe request signal table: one request in, one result out.
// A request is accepted only while the engine is idle; the single read port of the table memory
// then scans the filled slots one entry per cycle (at most the table size of 16) until a hit or
// the last filled slot. The result waits in the update state until the output register takes it,
// and only then is the next request accepted.
// Reset clears the event counter and the control state; table contents stay undefined.
module probe_request_rssi_table import prt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	prt_req_if.sink   req,
	prt_res_if.source res
);

	mem_req_t mem;
	entry_t   rd_data;
	result_t  eng_data;
	logic     eng_valid;
	logic     eng_ready;
	logic     out_valid_q;
	result_t  out_data_q;

	prt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem       (mem),
		.rd_data   (rd_data),
		.res_data  (eng_data),
		.res_valid (eng_valid),
		.res_ready (eng_ready)
	);

	prt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_data)
	);

	// The output register frees the engine as soon as its result has been taken over.
	assign eng_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_ready) begin
			out_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_valid && eng_ready) begin
			out_data_q <= eng_data;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.was_hit          = out_data_q.was_hit;
	assign res.slot_used        = out_data_q.slot_used;
	assign res.lowest_strength  = out_data_q.lowest_strength;
	assign res.highest_strength = out_data_q.highest_strength;
	assign res.events_seen      = out_data_q.events_seen;

endmodule

// ----- sv/prt_ram.sv -----
module prt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/prt_engine.sv -----
`include "probe_request_rssi_table_defines.svh"

module prt_engine import prt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	prt_req_if.sink  req,
	output mem_req_t mem,
	input  entry_t   rd_data,
	output result_t  res_data,
	output logic     res_valid,
	input  logic     res_ready
);

	state_t state_q, state_d;

	logic [MAC_W-1:0]        mac_q;
	logic signed [SIG_W-1:0] sig_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    rd_valid_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    hit_q;
	logic [IDX_W-1:0]        slot_q;
	logic signed [SIG_W-1:0] lo_q;
	logic signed [SIG_W-1:0] hi_q;
	logic [EVT_W-1:0]        count_q;
	logic [IDX_W-1:0]        ptr_q;

	logic                    match;
	logic                    issue_ok;
	logic                    rd_en;
	logic                    req_fire;
	logic                    res_fire;
	logic signed [SIG_W-1:0] lo_new;
	logic signed [SIG_W-1:0] hi_new;
	logic [EVT_W-1:0]        count_inc;
	logic [IDX_W-1:0]        ptr_inc;
	logic [IDX_W+SLOT_W-1:0] slot_ext;

	// The read issued last cycle is compared now, so the scan runs one entry behind.
	assign match    = rd_valid_s1 && (rd_data.mac == mac_q);
	assign issue_ok = (idx_q < CNT_W'(TABLE_SIZE)) && (EVT_W'(idx_q) < count_q);
	assign req_fire = req.valid && req.ready;
	assign res_fire = res_valid && res_ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = !match && issue_ok;
				if (match || !issue_ok) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Only one bound moves per hit, the low one taking precedence.
	always_comb begin
		if (!hit_q) begin
			lo_new = sig_q;
			hi_new = sig_q;
		end else if (lo_q > sig_q) begin
			lo_new = sig_q;
			hi_new = hi_q;
		end else begin
			lo_new = lo_q;
			hi_new = (hi_q < sig_q) ? sig_q : hi_q;
		end
	end

	// Once the counter has wrapped it restarts at its top value, so the table stays full.
	assign count_inc = (count_q == COUNT_MAX) ? COUNT_TOP : count_q + EVT_W'(1);
	assign ptr_inc   = (count_q == COUNT_MAX) ? WRAP_SLOT :
		((ptr_q == LAST_SLOT) ? '0 : ptr_q + IDX_W'(1));
	assign slot_ext  = {{SLOT_W{1'b0}}, slot_q};

	assign mem.we        = res_fire;
	assign mem.waddr     = slot_q;
	assign mem.wdata.mac = mac_q;
	assign mem.wdata.lo  = lo_new;
	assign mem.wdata.hi  = hi_new;
	assign mem.re        = rd_en;
	assign mem.raddr     = idx_q[IDX_W-1:0];

	assign res_data.was_hit          = hit_q;
	assign res_data.slot_used        = slot_ext[SLOT_W-1:0];
	assign res_data.lowest_strength  = lo_new;
	assign res_data.highest_strength = hi_new;
	assign res_data.events_seen      = hit_q ? count_q : count_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			count_q     <= '0;
			ptr_q       <= '0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (res_fire && !hit_q) begin
				count_q <= count_inc;
				ptr_q   <= ptr_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[IDX_W-1:0];
		if (req_fire) begin
			mac_q <= req.station_mac;
			sig_q <= req.signal_strength;
			idx_q <= '0;
		end else if (rd_en) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (state_q == ST_SCAN) begin
			if (match) begin
				hit_q  <= 1'b1;
				slot_q <= rd_idx_s1;
				lo_q   <= rd_data.lo;
				hi_q   <= rd_data.hi;
			end else if (!issue_ok) begin
				hit_q  <= 1'b0;
				slot_q <= ptr_q;
			end
		end
	end

	`PRT_ASSERT(a_hit_slot_written, clk, arst_n, (state_q == ST_UPDATE && hit_q) |-> (EVT_W'(slot_q) < count_q), "hit on a slot that was never written")
	`PRT_ASSERT(a_count_top_sticky, clk, arst_n, count_q[EVT_W-1] |=> count_q[EVT_W-1], "event counter top bit cleared")
	`PRT_ASSERT(a_accept_starts_scan, clk, arst_n, req_fire |=> (state_q == ST_SCAN), "accepted request did not start a scan")
	`PRT_ASSERT(a_read_in_range, clk, arst_n, rd_en |-> (idx_q < CNT_W'(TABLE_SIZE)), "table read beyond its depth")
	`PRT_ASSERT_ALWAYS(a_no_stray_read, clk, (state_q != ST_SCAN) |-> !rd_valid_s1, "read data pending outside a scan")

endmodule

// ----- tb/sv/prt_checker.sv -----
`timescale 1ns / 100ps

module prt_checker import prt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	prt_req_if   req,
	prt_res_if   res,
	output int   outstanding,
	output int   mismatches
);

	entry_t           heard [TABLE_SIZE];
	logic [EVT_W-1:0] insert_total;
	result_t          awaited_q [$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Looks the station up among the filled slots and updates the table exactly as the
	// block should, returning the result that the request must produce.
	function automatic result_t record_probe(input logic [MAC_W-1:0] mac,
		input logic signed [SIG_W-1:0] sig);
		result_t                 r;
		int                      filled;
		int                      slot;
		logic signed [SIG_W-1:0] lo;
		logic signed [SIG_W-1:0] hi;
		r = '0;
		slot = 0;
		filled = (insert_total > EVT_W'(TABLE_SIZE)) ? TABLE_SIZE : int'(insert_total);
		for (int i = 0; i < filled && !r.was_hit; i++) begin
			if (heard[i].mac == mac) begin
				r.was_hit = 1'b1;
				slot = i;
			end
		end
		if (r.was_hit) begin
			lo = heard[slot].lo;
			hi = heard[slot].hi;
			// Only one bound may move per request, and the low one is tried first.
			if (lo > sig)
				lo = sig;
			else if (hi < sig)
				hi = sig;
			heard[slot].lo = lo;
			heard[slot].hi = hi;
		end else begin
			slot = int'(insert_total % TABLE_SIZE);
			heard[slot].mac = mac;
			heard[slot].lo = sig;
			heard[slot].hi = sig;
			// After a wrap the top bit stays set, so the table remains full.
			insert_total = (insert_total == COUNT_MAX) ? COUNT_TOP : insert_total + 1'b1;
		end
		r.slot_used = SLOT_W'(slot);
		r.lowest_strength = heard[slot].lo;
		r.highest_strength = heard[slot].hi;
		r.events_seen = insert_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			insert_total = '0;
			awaited_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready)
				awaited_q.push_back(record_probe(req.station_mac, req.signal_strength));
			if (res.valid && res.ready) begin
				if (awaited_q.size() == 0) begin
					report_mismatch("result transfer with nothing awaited", 64'(res.slot_used), 0);
				end else begin
					want = awaited_q.pop_front();
					if (res.was_hit !== want.was_hit)
						report_mismatch("was_hit", 64'(res.was_hit), 64'(want.was_hit));
					if (res.slot_used !== want.slot_used)
						report_mismatch("slot_used", 64'(res.slot_used), 64'(want.slot_used));
					if (res.lowest_strength !== want.lowest_strength)
						report_mismatch("lowest_strength", 64'(unsigned'(res.lowest_strength)),
							64'(unsigned'(want.lowest_strength)));
					if (res.highest_strength !== want.highest_strength)
						report_mismatch("highest_strength", 64'(unsigned'(res.highest_strength)),
							64'(unsigned'(want.highest_strength)));
					if (res.events_seen !== want.events_seen)
						report_mismatch("events_seen", 64'(res.events_seen), 64'(want.events_seen));
				end
			end
			outstanding <= awaited_q.size();
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import prt_pkg::*;

	localparam int POOL_SIZE = 24;
	localparam int RANDOM_ITEMS = 950;

	logic             clk;
	logic             arst_n;
	int               outstanding;
	int               mismatches;
	bit               sender_steady;
	logic [MAC_W-1:0] station_pool [POOL_SIZE];

	prt_req_if req ();
	prt_res_if res ();

	probe_request_rssi_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	prt_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.res         (res),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin : watchdog
		#1_000_000;
		$display("FAIL probe_request_rssi_table");
		$finish;
	end

	task automatic offer_probe(input logic [MAC_W-1:0] mac, input logic signed [SIG_W-1:0] sig);
		while (!sender_steady && $urandom_range(99) < 14) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.station_mac <= mac;
		req.signal_strength <= sig;
		do @(posedge clk); while (!req.ready);
	endtask

	// The count from the checker is registered, hence the task waits on the clock before it first looks.
	task automatic drain_results;
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [MAC_W-1:0] random_station();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Receiver: random stalls, one quiet stretch and one long hold-off that backs the block up.
	initial begin : sink_side
		int unsigned cycle_no;
		int unsigned hold_left;
		res.ready <= 1'b0;
		cycle_no = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no == 2500)
				hold_left = 400;
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (cycle_no >= 9000 && cycle_no < 13000) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= ($urandom_range(99) >= 14);
			end
		end
	end

	initial begin : source_side
		logic [MAC_W-1:0]        mac;
		logic signed [SIG_W-1:0] sig;
		int unsigned             pick;
		arst_n = 1'b0;
		sender_steady = 1'b0;
		req.valid <= 1'b0;
		req.station_mac <= '0;
		req.signal_strength <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of both fields, then lowering, raising and an equal signal on hits.
		offer_probe('0, 8'sd0);
		offer_probe('1, -8'sd128);
		offer_probe('0, -8'sd128);
		offer_probe('0, 8'sd127);
		offer_probe('0, 8'sd127);
		offer_probe('1, 8'sd127);
		offer_probe('1, -8'sd128);
		// Fill the remaining slots, then two more stations replace the two oldest entries.
		for (int i = 2; i < TABLE_SIZE + 2; i++)
			offer_probe({24'h02_1A_C4, 24'(i)}, SIG_W'(i * 9 - 70));
		// The first station was evicted, so it comes back as a new entry.
		offer_probe('0, 8'sd3);
		// A hit on the last slot of the scan.
		offer_probe({24'h02_1A_C4, 24'(TABLE_SIZE - 1)}, -8'sd128);
		drain_results();

		foreach (station_pool[k])
			station_pool[k] = random_station();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sender_steady = (n >= 400 && n < 550);
			if (n == 700)
				drain_results();
			if (n % 200 == 199)
				station_pool[$urandom_range(POOL_SIZE - 1)] = random_station();
			pick = $urandom_range(99);
			if (pick < 85)
				mac = station_pool[$urandom_range(POOL_SIZE - 1)];
			else if (pick < 95)
				mac = random_station();
			else
				mac = $urandom_range(1) ? '1 : '0;
			pick = $urandom_range(99);
			if (pick < 10)
				sig = -8'sd128;
			else if (pick < 20)
				sig = 8'sd127;
			else
				sig = SIG_W'($urandom_range(255));
			offer_probe(mac, sig);
		end
		sender_steady = 1'b0;
		drain_results();
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("PASS probe_request_rssi_table");
		else
			$display("FAIL probe_request_rssi_table");
		$finish;
	end

endmodule

// ----- probe_request_rssi_table.f -----
+incdir+sv
sv/prt_pkg.sv
sv/prt_stream_if.sv
sv/prt_ram.sv
sv/prt_engine.sv
sv/probe_request_rssi_table.sv
tb/sv/prt_checker.sv
tb/sv/testbench.sv
